@@ src/dcb_pkg.sv @@
// Shared constants, payload types and controller/datapath interface types for the coverage map.
`default_nettype none

package dcb_pkg;

	// Grid storage: one RAM word per row, one bit per column
	localparam int MAX_ROWS     = 256;
	localparam int MAX_COLS     = 256;
	localparam int ROW_W        = $clog2(MAX_ROWS);
	localparam int COL_W        = $clog2(MAX_COLS);

	// Field and register widths
	localparam int OP_W         = 2;
	localparam int GRID_W       = 9;
	localparam int RAD_W        = 6;
	localparam int RADIUS_EXTRA = 2;
	localparam int R_W          = 7;               // effective radius, up to 65
	localparam int RR_W         = 13;              // squared radius, up to 4225
	localparam int DIST_W       = RR_W + 1;        // sum of two squares
	localparam int COORD_W      = ROW_W + 2;       // signed row/column with margin
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_STAMP = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ROW_W-1:0] point_row;
		logic [COL_W-1:0] point_col;
	} in_item_t;

	typedef struct packed {
		logic cell_covered;
		logic all_covered;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // latch point, reset the walk counters
		logic clear;     // drop all rows, set the flag
		logic w_dec;     // shrink the half width by one
		logic d_adv;     // move to the next row distance
		logic side_set;  // switch to the row below the point
		logic row_rd;    // read the current stamp row
		logic row_wr;    // write back the merged stamp row
		logic chk_rd;    // read the checked row
		logic chk_out;   // present the check result
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic shrink;     // half width still too large for this row
		logic row_ok;     // current stamp row lies in the grid
		logic side_done;  // no further row left at this distance
		logic d_last;     // this distance is the outermost one
	} sts_t;

endpackage

`default_nettype wire

@@ src/disk_coverage_bitmap.sv @@
// Top level of the disk coverage bitmap: controller plus datapath.
//
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ------------------------------------
// command   in         start & !busy                item (op, point_row, point_col)
// result    out        done, one cycle, no stall    result (cell_covered, all_covered)
// config    in         cfg_we, no wait              cfg_idx, cfg_data (rows, cols, radius)
//
// A clear drops all row valid bits at once, with no sweep. A check reads the row,
// picks the bit and registers the result. A stamp with effective radius r walks distances
// 0..r-1, one row at distance 0 and two rows at every other distance. A row in the grid
// is read, then merged and written back through the one RAM port pair; a row outside it
// is skipped. Each distance first settles the half width, one step at a time, and the
// largest effective radius is 65. The RAM read-modify-write of each row sets the rate.
// Reset: asynchronous, clears all row valid bits (the map reads as empty) and sets the
// all-covered flag; the block is idle and ready as soon as reset is released.
// The receiver cannot stall results; busy is the only back pressure on commands.
`default_nettype none

module disk_coverage_bitmap (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire dcb_pkg::in_item_t                 item,
	output logic                                   done,
	output dcb_pkg::out_item_t                     result,
	input  wire logic                              cfg_we,
	input  wire logic [dcb_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [dcb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Command and status between the sequencer and the datapath
	dcb_pkg::cmd_t cmd;
	dcb_pkg::sts_t sts;

	// Sequencer: takes a transaction when idle, runs a clear, walks the disk rows or runs the check
	dcb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Datapath: registers, row map RAM, disk geometry, coverage flag
	dcb_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result),
		.done     (done)
	);

endmodule

`default_nettype wire

@@ src/dcb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/dcb_ctrl.sv @@
// Controller state machine: sequences clear, stamp row walk and check.
`default_nettype none

module dcb_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [dcb_pkg::OP_W-1:0]    op,
	input  wire dcb_pkg::sts_t               sts,
	output logic                             busy,
	output dcb_pkg::cmd_t                    cmd
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SHRINK  = 6'b000010,
		S_ROW_RD  = 6'b000100,
		S_ROW_WR  = 6'b001000,
		S_CHK_RD  = 6'b010000,
		S_CHK_OUT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op)
						dcb_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						dcb_pkg::OP_STAMP: begin
							cmd.load = 1'b1;
							state_d  = S_SHRINK;
						end
						dcb_pkg::OP_CHECK: begin
							cmd.load = 1'b1;
							state_d  = S_CHK_RD;
						end
						default: ;
					endcase
				end
			end
			S_SHRINK: begin
				if (sts.shrink) begin
					cmd.w_dec = 1'b1;
				end else begin
					state_d = S_ROW_RD;
				end
			end
			S_ROW_RD: begin
				if (sts.row_ok) begin
					cmd.row_rd = 1'b1;
					state_d    = S_ROW_WR;
				end else if (!sts.side_done) begin
					cmd.side_set = 1'b1;
				end else if (sts.d_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.d_adv = 1'b1;
					state_d   = S_SHRINK;
				end
			end
			S_ROW_WR: begin
				cmd.row_wr = 1'b1;
				if (!sts.side_done) begin
					cmd.side_set = 1'b1;
					state_d      = S_ROW_RD;
				end else if (sts.d_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.d_adv = 1'b1;
					state_d   = S_SHRINK;
				end
			end
			S_CHK_RD: begin
				cmd.chk_rd = 1'b1;
				state_d    = S_CHK_OUT;
			end
			S_CHK_OUT: begin
				cmd.chk_out = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ src/dcb_datapath.sv @@
// Datapath: configuration, row map RAM with row valid bits, disk geometry and check result.
`default_nettype none

module dcb_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [dcb_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [dcb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire dcb_pkg::in_item_t                 item,
	input  wire dcb_pkg::cmd_t                     cmd,
	output dcb_pkg::sts_t                          sts,
	output dcb_pkg::out_item_t                     result,
	output logic                                   done
);

	localparam int ROW_W   = dcb_pkg::ROW_W;
	localparam int COL_W   = dcb_pkg::COL_W;
	localparam int GRID_W  = dcb_pkg::GRID_W;
	localparam int RAD_W   = dcb_pkg::RAD_W;
	localparam int R_W     = dcb_pkg::R_W;
	localparam int RR_W    = dcb_pkg::RR_W;
	localparam int DIST_W  = dcb_pkg::DIST_W;
	localparam int COORD_W = dcb_pkg::COORD_W;
	localparam int NROWS   = dcb_pkg::MAX_ROWS;
	localparam int NCOLS   = dcb_pkg::MAX_COLS;

	// Configuration
	logic [GRID_W-1:0] rows_q;
	logic [GRID_W-1:0] cols_q;
	logic [RAD_W-1:0]  rad_q;
	logic [RR_W-1:0]   rr_q;
	logic [R_W-1:0]    r_new;
	logic [R_W-1:0]    r_eff;

	assign r_new = R_W'(cfg_data[RAD_W-1:0]) + R_W'(dcb_pkg::RADIUS_EXTRA);
	assign r_eff = R_W'(rad_q) + R_W'(dcb_pkg::RADIUS_EXTRA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= GRID_W'(NROWS);
			cols_q <= GRID_W'(NCOLS);
			rad_q  <= '0;
			rr_q   <= RR_W'(dcb_pkg::RADIUS_EXTRA * dcb_pkg::RADIUS_EXTRA);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dcb_pkg::CFG_GRID_ROWS: rows_q <= cfg_data[GRID_W-1:0];
				dcb_pkg::CFG_GRID_COLS: cols_q <= cfg_data[GRID_W-1:0];
				dcb_pkg::CFG_RADIUS: begin
					rad_q <= cfg_data[RAD_W-1:0];
					rr_q  <= RR_W'(RR_W'(r_new) * RR_W'(r_new));
				end
				default: ;
			endcase
		end
	end

	logic [GRID_W-1:0] nr;
	logic [GRID_W-1:0] nc;

	assign nr = (rows_q > GRID_W'(NROWS)) ? GRID_W'(NROWS) : rows_q;
	assign nc = (cols_q > GRID_W'(NCOLS)) ? GRID_W'(NCOLS) : cols_q;

	// Point and walk counters
	logic [ROW_W-1:0] pr_q;
	logic [COL_W-1:0] pc_q;
	logic [R_W-1:0]   w_q;
	logic [RR_W-1:0]  w2_q;
	logic [R_W-1:0]   d_q;
	logic [RR_W-1:0]  d2_q;
	logic             side_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pr_q <= item.point_row;
			pc_q <= item.point_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= '0;
			w2_q   <= '0;
			d_q    <= '0;
			d2_q   <= '0;
			side_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				w_q    <= r_eff;
				w2_q   <= rr_q;
				d_q    <= '0;
				d2_q   <= '0;
				side_q <= 1'b0;
			end
			if (cmd.w_dec) begin
				// (w-1)^2 = w^2 - 2w + 1
				w_q  <= w_q - R_W'(1);
				w2_q <= w2_q - RR_W'({w_q, 1'b0}) + RR_W'(1);
			end
			if (cmd.d_adv) begin
				// (d+1)^2 = d^2 + 2d + 1
				d_q    <= d_q + R_W'(1);
				d2_q   <= d2_q + RR_W'({d_q, 1'b0}) + RR_W'(1);
				side_q <= 1'b0;
			end
			if (cmd.side_set) begin
				side_q <= 1'b1;
			end
		end
	end

	// Current stamp row and its column span
	logic signed [COORD_W-1:0] pr_ext;
	logic signed [COORD_W-1:0] pc_ext;
	logic signed [COORD_W-1:0] d_ext;
	logic signed [COORD_W-1:0] w_ext;
	logic signed [COORD_W-1:0] row_s;
	logic signed [COORD_W-1:0] lo_s;
	logic signed [COORD_W-1:0] hi_s;
	logic [ROW_W-1:0]          row_addr;
	logic [NCOLS-1:0]          mask;

	assign pr_ext   = $signed(COORD_W'(pr_q));
	assign pc_ext   = $signed(COORD_W'(pc_q));
	assign d_ext    = $signed(COORD_W'(d_q));
	assign w_ext    = $signed(COORD_W'(w_q));
	assign row_s    = side_q ? (pr_ext + d_ext) : (pr_ext - d_ext);
	assign lo_s     = pc_ext - w_ext;
	assign hi_s     = pc_ext + w_ext;
	assign row_addr = row_s[ROW_W-1:0];

	always_comb begin
		for (int c = 0; c < NCOLS; c++) begin
			mask[c] = ($signed(COORD_W'(c)) >= lo_s) && ($signed(COORD_W'(c)) <= hi_s) &&
				(GRID_W'(c) < nc);
		end
	end

	assign sts.shrink    = (DIST_W'(w2_q) + DIST_W'(d2_q)) >= DIST_W'(rr_q);
	assign sts.row_ok    = !row_s[COORD_W-1] && (row_s[GRID_W-1:0] < nr);
	assign sts.side_done = (d_q == '0) || side_q;
	assign sts.d_last    = (R_W'(d_q + R_W'(1)) == r_eff);

	// Row map storage; a row whose valid bit is low reads as all zeros
	logic [NROWS-1:0] vld_q;
	logic [ROW_W-1:0] rd_addr;
	logic [NCOLS-1:0] rd_row;
	logic [NCOLS-1:0] wr_row;

	assign rd_addr = cmd.chk_rd ? pr_q : row_addr;
	assign wr_row  = (vld_q[row_addr] ? rd_row : '0) | mask;

	dcb_ram #(
		.WIDTH(NCOLS),
		.DEPTH(NROWS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.row_wr),
		.waddr (row_addr),
		.wdata (wr_row),
		.re    (cmd.row_rd | cmd.chk_rd),
		.raddr (rd_addr),
		.rdata (rd_row)
	);

	// Check result
	logic covered;
	logic flag_q;

	assign covered = (GRID_W'(pr_q) < nr) && (GRID_W'(pc_q) < nc) && vld_q[pr_q] &&
		rd_row[pc_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			flag_q <= 1'b1;
			done   <= 1'b0;
		end else begin
			done <= cmd.chk_out;
			if (cmd.clear) begin
				vld_q  <= '0;
				flag_q <= 1'b1;
			end
			if (cmd.row_wr) begin
				vld_q[row_addr] <= 1'b1;
			end
			if (cmd.chk_out) begin
				flag_q <= flag_q & covered;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.chk_out) begin
			result.cell_covered <= covered;
			result.all_covered  <= flag_q & covered;
		end
	end

endmodule

`default_nettype wire

@@ src/dcb_checker.sv @@
// Port-level checker for the disk coverage bitmap, bound to the top level.
`default_nettype none

module dcb_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire dcb_pkg::in_item_t  item,
	input wire logic               done,
	input wire dcb_pkg::out_item_t result
);

	// A check transaction taken by the block must produce a result strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op == dcb_pkg::OP_CHECK) |-> ##3 done)
		else $error("check result missing");

	// Results never come in consecutive cycles
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// The running flag cannot be set if the current cell is uncovered
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.all_covered) |-> result.cell_covered)
		else $error("all_covered set on an uncovered cell");

	// A clear leaves the block not busy in the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op == dcb_pkg::OP_CLEAR) |=> !busy)
		else $error("busy after clear");

endmodule

bind disk_coverage_bitmap dcb_checker u_dcb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

`default_nettype wire
